// File: hdl/cbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

    localparam int FILTER_SIZE = 1024;

    localparam int LEN_W    = 11;
    localparam int KEY_W    = 7;
    localparam int ENT_W    = 7;
    localparam int REM_W    = 11;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int FNV_W    = 64;
    localparam int DJB_W    = 32;
    localparam int SDBM_W   = 32;

    localparam logic [LEN_W-1:0]  LEN_RESET = 11'd1024;
    localparam logic [FNV_W-1:0]  FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [DJB_W-1:0]  DJB_INIT  = 32'd5381;
    localparam logic [SDBM_W-1:0] SDBM_INIT = 32'd0;
    localparam logic [REM_W-1:0]  SIG_MOD   = 11'd58;
    localparam logic [ENT_W-1:0]  SIG_BIAS  = 7'd63;
    localparam logic [ENT_W-1:0]  FILL_CHAR = 7'd97;

    // register index, taken from paddr[2]
    localparam logic REG_FILTER_LENGTH = 1'b0;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key_byte;
        logic             byte_valid;
        logic             key_last;
    } t_in_item;

    typedef struct packed {
        logic done_kind;
        logic found;
    } t_out_item;

    typedef struct packed {
        logic [REM_W-1:0] rem_a;
        logic [REM_W-1:0] rem_b;
        logic [REM_W-1:0] rem_s;
    } t_mod_res;

endpackage

`default_nettype wire

// File: hdl/cbf_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_hash (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire cbf_pkg::t_in_item          i_item,
    output logic [cbf_pkg::FNV_W-1:0]       o_fnv,
    output logic [cbf_pkg::DJB_W-1:0]       o_djb,
    output logic [cbf_pkg::SDBM_W-1:0]      o_sdbm
);

    logic [cbf_pkg::FNV_W-1:0]  r_fnv, n_fnv, fnv_upd;
    logic [cbf_pkg::DJB_W-1:0]  r_djb, n_djb, djb_upd;
    logic [cbf_pkg::SDBM_W-1:0] r_sdbm, n_sdbm, sdbm_upd;

    // FNV prime is 2^40 + 0x1B3: multiply by shifted adds
    always_comb begin
        fnv_upd = (r_fnv << 40) + (r_fnv << 8) + (r_fnv << 7) + (r_fnv << 5)
                + (r_fnv << 4) + (r_fnv << 1) + r_fnv;
        fnv_upd = fnv_upd ^ cbf_pkg::FNV_W'(i_item.key_byte);
        djb_upd = (r_djb << 5) + r_djb + cbf_pkg::DJB_W'(i_item.key_byte);
        sdbm_upd = cbf_pkg::SDBM_W'(i_item.key_byte) + (r_sdbm << 6) + (r_sdbm << 16)
                 - r_sdbm;
    end

    assign o_fnv  = i_item.byte_valid ? fnv_upd  : r_fnv;
    assign o_djb  = i_item.byte_valid ? djb_upd  : r_djb;
    assign o_sdbm = i_item.byte_valid ? sdbm_upd : r_sdbm;

    always_comb begin
        n_fnv  = r_fnv;
        n_djb  = r_djb;
        n_sdbm = r_sdbm;
        if (i_step) begin
            if (i_item.key_last) begin
                n_fnv  = cbf_pkg::FNV_BASIS;
                n_djb  = cbf_pkg::DJB_INIT;
                n_sdbm = cbf_pkg::SDBM_INIT;
            end else begin
                n_fnv  = o_fnv;
                n_djb  = o_djb;
                n_sdbm = o_sdbm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fnv  <= cbf_pkg::FNV_BASIS;
            r_djb  <= cbf_pkg::DJB_INIT;
            r_sdbm <= cbf_pkg::SDBM_INIT;
        end else begin
            r_fnv  <= n_fnv;
            r_djb  <= n_djb;
            r_sdbm <= n_sdbm;
        end
    end

endmodule

`default_nettype wire

// File: hdl/cbf_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_mod (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [cbf_pkg::LEN_W-1:0]  i_len,
    input  wire logic [cbf_pkg::FNV_W-1:0]  i_fnv,
    input  wire logic [cbf_pkg::DJB_W-1:0]  i_djb,
    input  wire logic [cbf_pkg::SDBM_W-1:0] i_sdbm,
    output logic                            o_done,
    output cbf_pkg::t_mod_res               o_res
);

    localparam int DIG   = 4;
    localparam int SH_W  = cbf_pkg::FNV_W;
    localparam int NSTEP = SH_W / DIG;
    localparam int CNT_W = $clog2(NSTEP);

    // floor(sdbm / 58) equals floor((sdbm >> 1) / 29), which is the top bits of the
    // 31-bit value times ceil(2^36 / 29)
    localparam int                         RCP_SH  = 36;
    localparam int                         PROD_W  = 2 * cbf_pkg::SDBM_W - 1;
    localparam int                         QUO_W   = PROD_W - RCP_SH;
    localparam logic [cbf_pkg::SDBM_W-1:0] SIG_RCP = 32'd2369637129;

    logic [SH_W-1:0]            r_sh_a, r_sh_b;
    logic [cbf_pkg::SDBM_W-1:0] r_sdbm;
    logic [QUO_W-1:0]           r_quo;
    logic [cbf_pkg::REM_W-1:0]  r_div;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    cbf_pkg::t_mod_res          r_res;
    logic [PROD_W-1:0]          sig_prod;
    logic [cbf_pkg::SDBM_W-1:0] sig_rem;

    // shift in DIG dividend bits, MSB first, keeping rem below d
    function automatic logic [cbf_pkg::REM_W-1:0] rem_step(
        input logic [cbf_pkg::REM_W-1:0] rem,
        input logic [DIG-1:0]            dig,
        input logic [cbf_pkg::REM_W-1:0] d
    );
        logic [cbf_pkg::REM_W:0] t;
        logic [cbf_pkg::REM_W-1:0] r;
        r = rem;
        for (int i = DIG - 1; i >= 0; i--) begin
            t = {r, dig[i]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
            end
            r = t[cbf_pkg::REM_W-1:0];
        end
        return r;
    endfunction

    assign sig_prod = PROD_W'(r_sdbm[cbf_pkg::SDBM_W-1:1]) * PROD_W'(SIG_RCP);
    assign sig_rem  = r_sdbm
                    - cbf_pkg::SDBM_W'(r_quo) * cbf_pkg::SDBM_W'(cbf_pkg::SIG_MOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh_a <= i_fnv;
            r_sh_b <= SH_W'(i_djb);
            r_sdbm <= i_sdbm;
            r_div  <= i_len;
            r_res  <= '0;
        end else if (r_busy) begin
            r_res.rem_a <= rem_step(r_res.rem_a, r_sh_a[SH_W-1 -: DIG], r_div);
            r_res.rem_b <= rem_step(r_res.rem_b, r_sh_b[SH_W-1 -: DIG], r_div);
            r_sh_a <= r_sh_a << DIG;
            r_sh_b <= r_sh_b << DIG;
            // quotient on the first pass, signature remainder on the second
            if (r_cnt == '0) begin
                r_quo <= sig_prod[PROD_W-1:RCP_SH];
            end
            if (r_cnt == CNT_W'(1)) begin
                r_res.rem_s <= cbf_pkg::REM_W'(sig_rem);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: hdl/cbf_store.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_store #(
    parameter int FILTER_SIZE = cbf_pkg::FILTER_SIZE,
    parameter int AW = (FILTER_SIZE > 1) ? $clog2(FILTER_SIZE) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_addr,
    input  wire logic [cbf_pkg::ENT_W-1:0]  i_wr_data,
    output logic [cbf_pkg::ENT_W-1:0]       o_rd_data,
    output logic                            o_clearing
);

    logic [cbf_pkg::ENT_W-1:0] mem [FILTER_SIZE];
    logic [cbf_pkg::ENT_W-1:0] r_rd_data;
    logic [AW-1:0]             r_clr_addr;
    logic                      r_clr_busy;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [cbf_pkg::ENT_W-1:0] wr_data;

    always_comb begin
        wr_en   = r_clr_busy | i_wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_addr;
        wr_data = r_clr_busy ? cbf_pkg::FILL_CHAR : i_wr_data;
    end

    // sweep every entry to the fill value after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(FILTER_SIZE - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule

`default_nettype wire

// File: hdl/character_bloom_filter_core.sv
// Bytes: key bytes that are not the last are taken at one byte per cycle while idle and not clearing.
// Key end: after the last byte's transfer the remainder unit runs (4 dividend bits per
//   cycle, 16 passes), then the store is read (and written on insert) at index a, then b.
// Input stays blocked from the last byte's transfer until the result is loaded.
// Reset: synchronous, active low; then a clearing pass over all FILTER_SIZE entries fills
//   the store with 'a' while input is held off (configuration writes still taken).
`timescale 1ns / 1ps
`default_nettype none

module character_bloom_filter_core #(
    parameter int FILTER_SIZE = cbf_pkg::FILTER_SIZE
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire cbf_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output cbf_pkg::t_out_item               o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cbf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [cbf_pkg::DATA_W-1:0]  pwdata,
    output logic [cbf_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    localparam int AW = (FILTER_SIZE > 1) ? $clog2(FILTER_SIZE) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_MODA = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_MODB = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                 r_state, n_state;
    logic [cbf_pkg::LEN_W-1:0]  r_len;
    logic [cbf_pkg::LEN_W-1:0]  eff_len;
    logic                       r_kind;
    logic [cbf_pkg::ENT_W-1:0]  r_da;
    logic                       r_found;
    logic                       r_out_valid;
    cbf_pkg::t_out_item         r_out;

    logic                       in_xfer, key_end, cfg_wr, clearing;
    logic [cbf_pkg::FNV_W-1:0]  fnv_h;
    logic [cbf_pkg::DJB_W-1:0]  djb_h;
    logic [cbf_pkg::SDBM_W-1:0] sdbm_h;
    logic                       mod_done;
    cbf_pkg::t_mod_res          mod_res;
    logic [cbf_pkg::ENT_W-1:0]  sig;
    logic [AW-1:0]              idx_a, idx_b;
    logic                       mem_rd, mem_wr;
    logic [AW-1:0]              mem_addr;
    logic [cbf_pkg::ENT_W-1:0]  mem_wdata, mem_rdata;
    logic                       hit_a, hit_b;
    logic                       out_free;

    assign in_xfer  = i_in_valid & o_in_ready;
    assign key_end  = in_xfer & i_in_data.key_last;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign out_free = ~r_out_valid | i_out_ready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= cbf_pkg::LEN_RESET;
        end else if (cfg_wr && paddr[2] == cbf_pkg::REG_FILTER_LENGTH) begin
            r_len <= pwdata[cbf_pkg::LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cbf_pkg::REG_FILTER_LENGTH)
                  ? cbf_pkg::DATA_W'(r_len) : '0;

    always_comb begin
        if (r_len == '0) begin
            eff_len = cbf_pkg::LEN_W'(1);
        end else if (32'(r_len) > 32'(FILTER_SIZE)) begin
            eff_len = cbf_pkg::LEN_W'(FILTER_SIZE);
        end else begin
            eff_len = r_len;
        end
    end

    cbf_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_xfer),
        .i_item  (i_in_data),
        .o_fnv   (fnv_h),
        .o_djb   (djb_h),
        .o_sdbm  (sdbm_h)
    );

    cbf_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_end),
        .i_len   (eff_len),
        .i_fnv   (fnv_h),
        .i_djb   (djb_h),
        .i_sdbm  (sdbm_h),
        .o_done  (mod_done),
        .o_res   (mod_res)
    );

    assign sig   = mod_res.rem_s[cbf_pkg::ENT_W-1:0] + cbf_pkg::SIG_BIAS;
    assign idx_a = AW'(mod_res.rem_a);
    assign idx_b = AW'(mod_res.rem_b);

    // second read follows the first write, so a shared entry sees the update
    always_comb begin
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        mem_addr  = idx_a;
        mem_wdata = mem_rdata | sig;
        case (r_state)
            S_RDA: begin
                mem_rd = 1'b1;
            end
            S_MODA: begin
                mem_wr = (r_kind == cbf_pkg::REQ_INSERT);
            end
            S_RDB: begin
                mem_rd   = 1'b1;
                mem_addr = idx_b;
            end
            S_MODB: begin
                mem_wr   = (r_kind == cbf_pkg::REQ_INSERT);
                mem_addr = idx_b;
            end
            default: begin
                mem_rd = 1'b0;
            end
        endcase
    end

    cbf_store #(
        .FILTER_SIZE (FILTER_SIZE),
        .AW          (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (mem_rd),
        .i_wr_en    (mem_wr),
        .i_addr     (mem_addr),
        .i_wr_data  (mem_wdata),
        .o_rd_data  (mem_rdata),
        .o_clearing (clearing)
    );

    assign hit_a = ((r_da & sig) == sig);
    assign hit_b = ((mem_rdata & sig) == sig);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (key_end) n_state = S_DIV;
            S_DIV:  if (mod_done) n_state = S_RDA;
            S_RDA:  n_state = S_MODA;
            S_MODA: n_state = S_RDB;
            S_RDB:  n_state = S_MODB;
            S_MODB: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_end) begin
            r_kind <= i_in_data.req_type;
        end
        if (r_state == S_MODA) begin
            r_da <= mem_rdata;
        end
        if (r_state == S_MODB) begin
            r_found <= (r_kind == cbf_pkg::REQ_QUERY) & hit_a & hit_b;
        end
        if (r_state == S_OUT && out_free) begin
            r_out.done_kind <= r_kind;
            r_out.found     <= r_found;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) & ~clearing;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: hdl/cbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        o_in_ready,
    input  wire cbf_pkg::t_in_item           i_in_data,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    input  wire cbf_pkg::t_out_item          o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cbf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [cbf_pkg::DATA_W-1:0]  pwdata,
    input  wire logic [cbf_pkg::DATA_W-1:0]  prdata,
    input  wire logic                        pready
);

    // reset starts the clearing pass: no input, no result
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_ready && !o_out_valid))
        else $error("input open or result shown right after reset");

    // a key end holds input off while the lookup runs
    a_key_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.key_last) |=> !o_in_ready)
        else $error("input taken during key-end processing");

    // an insert never reports found
    a_insert_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.done_kind == cbf_pkg::REQ_QUERY || !o_out_data.found))
        else $error("insert result with found set");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed under stall");

endmodule

bind character_bloom_filter_core cbf_checker u_cbf_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [cbf_pkg::FNV_W-1:0] FNV_MUL = 64'd1099511628211;
    localparam int                ITEM_TARGET    = 1600;
    localparam int                PHASE_ITEMS    = 150;
    localparam int                SETTLE_CYCLES  = 30;
    localparam int                TAIL_CYCLES    = 40;
    localparam int                WATCHDOG_LIMIT = 4 * cbf_pkg::FILTER_SIZE + 400;
    localparam int                MAX_KEY        = 20;
    localparam int                POOL_DEPTH     = 64;
    localparam int                NUM_PHASE_LENS = 8;
    localparam int                PHASE_LENS [NUM_PHASE_LENS] =
        '{1, 2047, 7, 0, 1024, 64, 1023, 3};
    localparam logic [cbf_pkg::ADDR_W-1:0] ADDR_FILTER_LENGTH =
        {cbf_pkg::REG_FILTER_LENGTH, 2'b00};
    localparam logic [cbf_pkg::ADDR_W-1:0] ADDR_UNMAPPED      = 3'b100;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    cbf_pkg::t_in_item          in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    cbf_pkg::t_out_item         out_data;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [cbf_pkg::ADDR_W-1:0] paddr     = '0;
    logic [cbf_pkg::DATA_W-1:0] pwdata    = '0;
    logic [cbf_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // filter mirror and running hashes
    logic [cbf_pkg::LEN_W-1:0]  cfg_len;
    logic [cbf_pkg::FNV_W-1:0]  fnv_acc;
    logic [cbf_pkg::DJB_W-1:0]  djb_acc;
    logic [cbf_pkg::SDBM_W-1:0] sdbm_acc;
    logic [cbf_pkg::ENT_W-1:0]  filter_mirror [cbf_pkg::FILTER_SIZE];
    cbf_pkg::t_out_item         pending_results [$];

    logic [cbf_pkg::KEY_W-1:0]  key_buf [MAX_KEY];
    logic [cbf_pkg::KEY_W-1:0]  key_pool [POOL_DEPTH][MAX_KEY];
    int                key_pool_len [POOL_DEPTH];
    int                pool_count = 0;

    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    int rx_wait = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int counted_items = 0;
    int ignored_items = 0;
    int inserts_sent = 0;
    int queries_sent = 0;
    int found_seen = 0;
    int length_settings = 0;

    always #1 clk = ~clk;

    character_bloom_filter_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    task automatic note_mismatch(input string what, input logic [31:0] exp,
                                 input logic [31:0] act);
        mismatches++;
        if (mismatches <= 10) begin
            $display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, exp, act,
                     $realtime);
        end
    endtask

    // advance the hashes by one item; at a key end look up / update the mirror
    task automatic filter_step(input cbf_pkg::t_in_item it);
        logic [63:0]               span;
        logic [63:0]               idx_a;
        logic [63:0]               idx_b;
        logic [cbf_pkg::ENT_W-1:0] sig;
        cbf_pkg::t_out_item        res;
        if (it.byte_valid) begin
            fnv_acc  = (fnv_acc * FNV_MUL) ^ cbf_pkg::FNV_W'(it.key_byte);
            djb_acc  = (djb_acc << 5) + djb_acc + cbf_pkg::DJB_W'(it.key_byte);
            sdbm_acc = cbf_pkg::SDBM_W'(it.key_byte) + (sdbm_acc << 6) + (sdbm_acc << 16)
                     - sdbm_acc;
        end
        if (it.key_last) begin
            if (cfg_len == '0)
                span = 64'd1;
            else if (cfg_len > cbf_pkg::FILTER_SIZE)
                span = 64'(cbf_pkg::FILTER_SIZE);
            else
                span = 64'(cfg_len);
            idx_a = fnv_acc % span;
            idx_b = 64'(djb_acc) % span;
            sig = cbf_pkg::ENT_W'((sdbm_acc % cbf_pkg::SIG_MOD) + cbf_pkg::SIG_BIAS);
            res.done_kind = it.req_type;
            res.found = 1'b0;
            if (it.req_type == cbf_pkg::REQ_INSERT) begin
                filter_mirror[idx_a] = filter_mirror[idx_a] | sig;
                filter_mirror[idx_b] = filter_mirror[idx_b] | sig;
            end else begin
                res.found = ((filter_mirror[idx_a] & sig) == sig) &&
                            ((filter_mirror[idx_b] & sig) == sig);
            end
            pending_results.push_back(res);
            fnv_acc  = cbf_pkg::FNV_BASIS;
            djb_acc  = cbf_pkg::DJB_INIT;
            sdbm_acc = cbf_pkg::SDBM_INIT;
        end
    endtask

    // called and returns at a falling edge
    task automatic send_item(input cbf_pkg::t_in_item it);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 8);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        filter_step(it);
        if (!it.byte_valid && !it.key_last)
            ignored_items++;
        else
            counted_items++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_noise();
        cbf_pkg::t_in_item it;
        it.req_type   = 1'($urandom);
        it.key_byte   = cbf_pkg::KEY_W'($urandom);
        it.byte_valid = 1'b0;
        it.key_last   = 1'b0;
        send_item(it);
    endtask

    // send key_buf[0..len-1]; a broken key mixes in dropped bytes and a wavering req_type
    task automatic send_key(input logic kind, input int len, input bit broken);
        cbf_pkg::t_in_item it;
        if (len == 0) begin
            it.req_type   = kind;
            it.key_byte   = cbf_pkg::KEY_W'($urandom);
            it.byte_valid = 1'b0;
            it.key_last   = 1'b1;
            send_item(it);
        end else begin
            for (int k = 0; k < len; k++) begin
                if (broken && $urandom_range(0, 3) == 0)
                    send_noise();
                it.req_type   = (broken && k != len - 1) ? 1'($urandom) : kind;
                it.key_byte   = key_buf[k];
                it.byte_valid = 1'b1;
                it.key_last   = (k == len - 1);
                send_item(it);
            end
        end
        if (kind == cbf_pkg::REQ_INSERT)
            inserts_sent++;
        else
            queries_sent++;
    endtask

    // hold off until every result is in, then let the block finish any key-end work
    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [cbf_pkg::ADDR_W-1:0] addr,
                              input logic [cbf_pkg::DATA_W-1:0] wdata,
                              output logic [cbf_pkg::DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_length_readback();
        logic [cbf_pkg::DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_FILTER_LENGTH, '0, rd);
        if (rd !== cbf_pkg::DATA_W'(cfg_len))
            note_mismatch("filter_length readback", cbf_pkg::DATA_W'(cfg_len), rd);
    endtask

    task automatic set_filter_length(input logic [cbf_pkg::DATA_W-1:0] value);
        logic [cbf_pkg::DATA_W-1:0] rd;
        wait_idle();
        apb_access(1'b1, ADDR_FILTER_LENGTH, value, rd);
        cfg_len = value[cbf_pkg::LEN_W-1:0];
        length_settings++;
        check_length_readback();
    endtask

    task automatic test_reset_state();
        check_length_readback();
        send_key(cbf_pkg::REQ_QUERY, 0, 1'b0);
        key_buf[0] = 7'h00;
        send_key(cbf_pkg::REQ_QUERY, 1, 1'b0);
        key_buf[0] = 7'h7F;
        send_key(cbf_pkg::REQ_QUERY, 1, 1'b0);
    endtask

    task automatic test_field_extremes();
        key_buf[0] = 7'h00;
        key_buf[1] = 7'h7F;
        key_buf[2] = 7'h55;
        key_buf[3] = 7'h2A;
        send_key(cbf_pkg::REQ_INSERT, 4, 1'b0);
        send_noise();
        send_key(cbf_pkg::REQ_QUERY, 4, 1'b0);
        send_key(cbf_pkg::REQ_INSERT, 0, 1'b0);
        send_key(cbf_pkg::REQ_QUERY, 0, 1'b0);
    endtask

    task automatic test_length_extremes();
        logic [cbf_pkg::DATA_W-1:0] rd;
        set_filter_length(32'd0);
        key_buf[0] = 7'h41;
        send_key(cbf_pkg::REQ_INSERT, 1, 1'b0);
        key_buf[0] = 7'h5A;
        send_key(cbf_pkg::REQ_QUERY, 1, 1'b0);
        set_filter_length(32'hFFFF_FFFF);
        key_buf[0] = 7'h33;
        send_key(cbf_pkg::REQ_INSERT, 1, 1'b0);
        send_key(cbf_pkg::REQ_QUERY, 1, 1'b0);
        // the unmapped slot must leave the length alone
        wait_idle();
        apb_access(1'b1, ADDR_UNMAPPED, 32'd5, rd);
        check_length_readback();
        set_filter_length(32'd1);
        send_key(cbf_pkg::REQ_QUERY, 1, 1'b0);
    endtask

    task automatic test_length_mid_key();
        cbf_pkg::t_in_item it;
        for (int k = 0; k < 3; k++) key_buf[k] = cbf_pkg::KEY_W'($urandom);
        it.req_type   = cbf_pkg::REQ_INSERT;
        it.byte_valid = 1'b1;
        it.key_last   = 1'b0;
        for (int k = 0; k < 2; k++) begin
            it.key_byte = key_buf[k];
            send_item(it);
        end
        set_filter_length(32'd13);
        it.key_byte = key_buf[2];
        it.key_last = 1'b1;
        send_item(it);
        inserts_sent++;
        send_key(cbf_pkg::REQ_QUERY, 3, 1'b0);
    endtask

    task automatic test_random_traffic();
        int                         start;
        int                         phase;
        int                         phase_end;
        int                         pick;
        int                         len;
        int                         slot;
        int                         r;
        logic                       kind;
        logic [cbf_pkg::DATA_W-1:0] value;
        start = counted_items;
        phase = 0;
        while (counted_items - start < ITEM_TARGET) begin
            value = (phase < NUM_PHASE_LENS) ? cbf_pkg::DATA_W'(PHASE_LENS[phase])
                                             : cbf_pkg::DATA_W'($urandom_range(0, 2047));
            if (phase % 2 == 1)
                value = (cbf_pkg::DATA_W'($urandom) & ~32'h7FF) | value;
            set_filter_length(value);
            tx_no_idle = (phase % 4 == 2);
            rx_no_idle = (phase % 3 == 1);
            phase_end = counted_items + PHASE_ITEMS;
            while (counted_items < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_noise();
                end else begin
                    kind = (pick < 50) ? cbf_pkg::REQ_INSERT : cbf_pkg::REQ_QUERY;
                    if (kind == cbf_pkg::REQ_QUERY && pool_count != 0
                        && $urandom_range(0, 1)) begin
                        // replay a key inserted earlier
                        slot = $urandom_range(0, (pool_count < POOL_DEPTH ? pool_count
                                                                          : POOL_DEPTH) - 1);
                        len = key_pool_len[slot];
                        for (int k = 0; k < len; k++) key_buf[k] = key_pool[slot][k];
                    end else begin
                        r = $urandom_range(0, 19);
                        if (r == 0)
                            len = 0;
                        else if (r == 1)
                            len = $urandom_range(9, MAX_KEY);
                        else
                            len = $urandom_range(1, 8);
                        for (int k = 0; k < len; k++) key_buf[k] = cbf_pkg::KEY_W'($urandom);
                    end
                    send_key(kind, len, pick >= 92);
                    if (kind == cbf_pkg::REQ_INSERT) begin
                        slot = pool_count % POOL_DEPTH;
                        key_pool_len[slot] = len;
                        for (int k = 0; k < len; k++) key_pool[slot][k] = key_buf[k];
                        pool_count++;
                    end
                end
            end
            phase++;
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    always @(negedge clk) begin
        if (rx_wait > 0) begin
            out_ready <= 1'b0;
            rx_wait--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_results
        cbf_pkg::t_out_item exp;
        if (out_valid && out_ready) begin
            rx_wait = rx_no_idle ? 0 : $urandom_range(0, 8);
            if (pending_results.size() == 0) begin
                note_mismatch("result with none pending", '0, 32'(out_data));
            end else begin
                exp = pending_results.pop_front();
                if (out_data.done_kind !== exp.done_kind)
                    note_mismatch("done_kind", 32'(exp.done_kind), 32'(out_data.done_kind));
                if (out_data.found !== exp.found)
                    note_mismatch("found", 32'(exp.found), 32'(out_data.found));
                if (exp.found)
                    found_seen++;
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int e;
        for (e = 0; e < cbf_pkg::FILTER_SIZE; e++) filter_mirror[e] = cbf_pkg::FILL_CHAR;
        cfg_len  = cbf_pkg::LEN_RESET;
        fnv_acc  = cbf_pkg::FNV_BASIS;
        djb_acc  = cbf_pkg::DJB_INIT;
        sdbm_acc = cbf_pkg::SDBM_INIT;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_field_extremes();
        test_length_extremes();
        test_length_mid_key();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("tb: %0d keys (%0d inserts, %0d queries, %0d reported found), %0d key items",
                 inserts_sent + queries_sent, inserts_sent, queries_sent, found_seen,
                 counted_items);
        $display("tb: %0d dropped bytes, %0d filter_length settings, %0d mismatches",
                 ignored_items, length_settings, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: character_bloom_filter_core.f
hdl/cbf_pkg.sv
hdl/cbf_hash.sv
hdl/cbf_mod.sv
hdl/cbf_store.sv
hdl/character_bloom_filter_core.sv
hdl/cbf_checker.sv
tb/tb_top.sv
